// ===== rtl/core/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg
// Types and constants shared by the sorted ready queue and its cells.
// ----------------------------------------------------------------------------
package prq_pkg;

    localparam int DEPTH     = 16;
    localparam int PRIO_BITS = 8;
    localparam int TASK_BITS = 8;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    // request operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    // what every cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_CLEAR  = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] task_id;
        logic [7:0] task_priority;
    } in_t;

    typedef struct packed {
        logic       removed_valid;
        logic [7:0] removed_task;
        logic [7:0] removed_priority;
        logic       head_valid;
        logic [7:0] head_task;
        logic [7:0] head_priority;
        logic [4:0] entry_count;
        logic       insert_dropped;
    } out_t;

    typedef struct packed {
        logic                 valid;
        logic [PRIO_BITS-1:0] prio;
        logic [TASK_BITS-1:0] task_id;
    } slot_t;

    // what a cell shows its neighbours
    typedef struct packed {
        slot_t slot;
        logic  gt;   // holds an entry less urgent than the one being inserted
    } link_t;

    // broadcast to the whole row
    typedef struct packed {
        cell_op_t             op;
        logic [PRIO_BITS-1:0] prio;
        logic [TASK_BITS-1:0] task_id;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/prq_cell.sv =====
// ----------------------------------------------------------------------------
// prq_cell
// One slot of the sorted queue: keeps its entry, shifts towards the tail on
// an insert ahead of it and towards the head on a remove.
// ----------------------------------------------------------------------------
module prq_cell
    import prq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl_i,
    input  link_t      left_i,
    input  link_t      right_i,
    output link_t      link_o
);

    logic                 valid_reg, valid_next;
    logic [PRIO_BITS-1:0] prio_reg, prio_next;
    logic [TASK_BITS-1:0] task_reg, task_next;
    logic                 gt;
    logic                 stays;

    assign gt    = valid_reg && (prio_reg > ctrl_i.prio);
    assign stays = valid_reg && !gt;

    always_comb begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        task_next  = task_reg;
        case (ctrl_i.op)
            CELL_INSERT: begin
                if (!stays) begin
                    if (left_i.gt) begin
                        valid_next = 1'b1;
                        prio_next  = left_i.slot.prio;
                        task_next  = left_i.slot.task_id;
                    end else if (left_i.slot.valid) begin
                        // insertion point sits here
                        valid_next = 1'b1;
                        prio_next  = ctrl_i.prio;
                        task_next  = ctrl_i.task_id;
                    end
                end
            end
            CELL_REMOVE: begin
                valid_next = right_i.slot.valid;
                prio_next  = right_i.slot.prio;
                task_next  = right_i.slot.task_id;
            end
            CELL_CLEAR: begin
                valid_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prio_reg <= prio_next;
        task_reg <= task_next;
    end

    assign link_o.slot.valid   = valid_reg;
    assign link_o.slot.prio    = prio_reg;
    assign link_o.slot.task_id = task_reg;
    assign link_o.gt           = gt;

endmodule

// ===== rtl/core/priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue
// Sorted ready queue: a row of cells, head in cell 0, equal priorities FIFO.
//
//   channel | dir | payload | handshake
//   s_      | in  | in_t    | s_valid / s_ready
//   m_      | out | out_t   | m_valid / m_ready
//
// One request per cycle while s_ready is high: every cell compares its priority
// with the broadcast one in parallel and picks its next entry from itself, a
// neighbour or the request, so insert, remove and clear each update the row at once.
// Reset clears the valid bits and the count directly; no clearing pass.
// s_ready drops only while a result is held and m_ready is low.
// ----------------------------------------------------------------------------
module priority_ready_queue
    import prq_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_payload,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_payload
);

    localparam link_t HEAD_LINK = '{slot: '{valid: 1'b1, prio: '0, task_id: '0}, gt: 1'b0};
    localparam link_t TAIL_LINK = '0;

    link_t            links [DEPTH];
    cell_ctrl_t       ctrl;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg;
    logic             removed_valid_reg, removed_valid_next;
    logic [7:0]       removed_task_reg, removed_task_next;
    logic [7:0]       removed_prio_reg, removed_prio_next;
    logic             dropped_reg, dropped_next;
    logic             accept;
    logic             full;
    logic             empty;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    always_comb begin
        ctrl.op            = CELL_HOLD;
        ctrl.prio          = s_payload.task_priority[PRIO_BITS-1:0];
        ctrl.task_id       = s_payload.task_id[TASK_BITS-1:0];
        count_next         = count_reg;
        removed_valid_next = 1'b0;
        removed_task_next  = '0;
        removed_prio_next  = '0;
        dropped_next       = 1'b0;
        if (accept) begin
            case (op_t'(s_payload.operation))
                OP_INSERT: begin
                    if (full) begin
                        dropped_next = 1'b1;
                    end else begin
                        ctrl.op    = CELL_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (!empty) begin
                        ctrl.op            = CELL_REMOVE;
                        count_next         = count_reg - 1'b1;
                        removed_valid_next = 1'b1;
                        removed_task_next  = 8'(links[0].slot.task_id);
                        removed_prio_next  = 8'(links[0].slot.prio);
                    end
                end
                OP_CLEAR: begin
                    ctrl.op    = CELL_CLEAR;
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        link_t left_link;
        link_t right_link;
        if (i == 0) begin : g_head
            assign left_link = HEAD_LINK;
        end else begin : g_mid
            assign left_link = links[i-1];
        end
        if (i == DEPTH - 1) begin : g_tail
            assign right_link = TAIL_LINK;
        end else begin : g_body
            assign right_link = links[i+1];
        end
        prq_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl_i  (ctrl),
            .left_i  (left_link),
            .right_i (right_link),
            .link_o  (links[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            removed_valid_reg <= removed_valid_next;
            removed_task_reg  <= removed_task_next;
            removed_prio_reg  <= removed_prio_next;
            dropped_reg       <= dropped_next;
        end
    end

    // queue state only moves on an accept, which waits until any held result is taken,
    // so head comes straight from the cells and count from the count register
    assign m_valid                    = m_valid_reg;
    assign m_payload.removed_valid    = removed_valid_reg;
    assign m_payload.removed_task     = removed_task_reg;
    assign m_payload.removed_priority = removed_prio_reg;
    assign m_payload.head_valid       = !empty;
    assign m_payload.head_task        = empty ? 8'd0 : 8'(links[0].slot.task_id);
    assign m_payload.head_priority    = empty ? 8'd0 : 8'(links[0].slot.prio);
    assign m_payload.entry_count      = 5'(count_reg);
    assign m_payload.insert_dropped   = dropped_reg;

`ifndef SYNTH
    logic [DEPTH-1:0] valid_vec;

    for (genvar j = 0; j < DEPTH; j++) begin : g_vvec
        assign valid_vec[j] = links[j].slot.valid;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_count_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("valid cells disagree with count");

    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        links[0].slot.valid == !empty)
        else $error("head cell valid disagrees with count");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_payload.operation == OP_INSERT) && !full
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted insert did not grow the queue");
`endif

endmodule

// ===== bench/priority_ready_queue_test.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue_test
// Self-checking bench for the sorted ready queue. Requests are drawn in
// phases (insert-heavy, balanced, pop-heavy) with narrow or wide priority
// spreads, so the queue runs full and empty and ties are common. Every
// accepted request is run through a shadow sorted queue here, and each
// result is compared field by field against the matching prediction.
// ----------------------------------------------------------------------------
module priority_ready_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import prq_pkg::*;

    localparam int         CLK_HALF     = 10;
    localparam int         RESET_CYCLES = 4;
    localparam int         RANDOM_REQS  = 1630;
    localparam int         LONG_HOLD    = 80;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         TAIL_CYCLES  = 8;
    localparam int         PRINT_CAP    = 100;
    localparam logic [1:0] OP_SPARE     = 2'd3;   // unused code, no effect

    typedef struct {
        in_t         req;
        int unsigned gap;
        bit          drain;   // hold back until every result is in
    } pending_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_payload;

    pending_t pending_reqs[$];
    out_t     predicted_status[$];

    // shadow of the sorted queue
    logic [PRIO_BITS-1:0] shadow_prio[DEPTH];
    logic [TASK_BITS-1:0] shadow_task[DEPTH];
    int                   shadow_count = 0;

    int n_errors  = 0;
    int n_results = 0;
    int n_inserts = 0;
    int n_dropped = 0;
    int n_pops    = 0;
    int n_empty   = 0;
    int n_clears  = 0;
    int n_spare   = 0;
    int max_fill  = 0;

    bit          tx_calm    = 1'b0;
    bit          gap_loaded = 1'b0;
    int unsigned send_wait  = 0;
    bit          rx_calm    = 1'b0;
    int unsigned rx_hold    = 0;
    int          idle_cycles = 0;

    priority_ready_queue u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Sorted insert after all entries of equal or more urgent priority,
    // pop from the head, clear; status shows head and count afterwards.
    function automatic void apply_request(in_t req);
        out_t                 res;
        int                   pos;
        logic [PRIO_BITS-1:0] prio;
        logic [TASK_BITS-1:0] tid;
        res  = '0;
        prio = req.task_priority[PRIO_BITS-1:0];
        tid  = req.task_id[TASK_BITS-1:0];
        case (req.operation)
            OP_INSERT: begin
                n_inserts++;
                if (shadow_count >= DEPTH) begin
                    res.insert_dropped = 1'b1;
                    n_dropped++;
                end else begin
                    pos = 0;
                    while (pos < shadow_count && shadow_prio[pos] <= prio)
                        pos++;
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_prio[i] = shadow_prio[i-1];
                        shadow_task[i] = shadow_task[i-1];
                    end
                    shadow_prio[pos] = prio;
                    shadow_task[pos] = tid;
                    shadow_count++;
                end
            end
            OP_REMOVE: begin
                if (shadow_count > 0) begin
                    res.removed_valid    = 1'b1;
                    res.removed_task     = 8'(shadow_task[0]);
                    res.removed_priority = 8'(shadow_prio[0]);
                    for (int i = 0; i + 1 < shadow_count; i++) begin
                        shadow_prio[i] = shadow_prio[i+1];
                        shadow_task[i] = shadow_task[i+1];
                    end
                    shadow_count--;
                    n_pops++;
                end else begin
                    n_empty++;
                end
            end
            OP_CLEAR: begin
                shadow_count = 0;
                n_clears++;
            end
            default: n_spare++;
        endcase
        if (shadow_count > 0) begin
            res.head_valid    = 1'b1;
            res.head_task     = 8'(shadow_task[0]);
            res.head_priority = 8'(shadow_prio[0]);
        end
        res.entry_count = 5'(shadow_count);
        if (shadow_count > max_fill)
            max_fill = shadow_count;
        predicted_status.push_back(res);
    endfunction

    task automatic report_mismatch(string msg);
        n_errors++;
        if (n_errors <= PRINT_CAP)
            $display("[%0t] result %0d: %s", $realtime, n_results, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    function automatic void push_req(logic [1:0] op, logic [7:0] tid,
                                     logic [7:0] prio, bit drain);
        pending_t p;
        p.req.operation     = op;
        p.req.task_id       = tid;
        p.req.task_priority = prio;
        p.gap               = tx_calm ? 0 : $urandom_range(3);
        p.drain             = drain;
        pending_reqs.push_back(p);
    endfunction

    // request driver
    always @(posedge aclk) begin
        logic next_valid;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            gap_loaded = 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                apply_request(s_payload);
                next_valid = 1'b0;
            end
            if (!next_valid && pending_reqs.size() != 0) begin
                if (!gap_loaded) begin
                    send_wait  = pending_reqs[0].gap;
                    gap_loaded = 1'b1;
                end
                if (send_wait != 0) begin
                    send_wait--;
                end else if (!pending_reqs[0].drain || predicted_status.size() == 0) begin
                    s_payload  <= pending_reqs[0].req;
                    pending_reqs.pop_front();
                    gap_loaded = 1'b0;
                    next_valid = 1'b1;
                end
            end
            s_valid <= next_valid;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_status.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = predicted_status.pop_front();
                    check_field("removed_valid", 8'(m_payload.removed_valid),
                                8'(want.removed_valid));
                    check_field("removed_task", m_payload.removed_task, want.removed_task);
                    check_field("removed_priority", m_payload.removed_priority,
                                want.removed_priority);
                    check_field("head_valid", 8'(m_payload.head_valid),
                                8'(want.head_valid));
                    check_field("head_task", m_payload.head_task, want.head_task);
                    check_field("head_priority", m_payload.head_priority,
                                want.head_priority);
                    check_field("entry_count", 8'(m_payload.entry_count),
                                8'(want.entry_count));
                    check_field("insert_dropped", 8'(m_payload.insert_dropped),
                                8'(want.insert_dropped));
                end
                n_results++;
                if (n_results % 64 == 0)
                    rx_calm = ($urandom_range(3) == 0);
                rx_hold = rx_calm ? 0 : $urandom_range(3);
                // long back-pressure so the queue stalls its request side
                if (n_results == 150 || n_results == 1000)
                    rx_hold = LONG_HOLD;
            end else if (rx_hold != 0) begin
                rx_hold--;
            end
            m_ready <= (rx_hold == 0);
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d idle cycles, %0d results outstanding",
                     IDLE_LIMIT, predicted_status.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int          n_random;
        int          phase_len;
        int          ins_pct;
        int          r;
        bit          narrow;
        bit          drain_first;
        logic [1:0]  op;
        logic [7:0]  prio;

        // directed: empty pop, extremes, ties, spare code, fill to overflow
        tx_calm = 1'b1;
        push_req(OP_REMOVE, 8'h5A, 8'hA5, 1'b0);
        push_req(OP_INSERT, 8'h00, 8'h00, 1'b0);
        push_req(OP_INSERT, 8'hFF, 8'hFF, 1'b0);
        push_req(OP_INSERT, 8'hAA, 8'h55, 1'b0);
        push_req(OP_INSERT, 8'h11, 8'h55, 1'b0);
        push_req(OP_INSERT, 8'h22, 8'h00, 1'b0);
        push_req(OP_REMOVE, 8'hFF, 8'hFF, 1'b0);
        push_req(OP_SPARE,  8'hFF, 8'hFF, 1'b0);
        tx_calm = 1'b0;
        for (int i = 0; i < DEPTH - 4 + 1; i++)
            push_req(OP_INSERT, 8'(8'h30 + i), 8'((i % 3) * 8'h40), 1'b0);
        push_req(OP_CLEAR, 8'h00, 8'h00, 1'b1);

        n_random = 0;
        while (n_random < RANDOM_REQS) begin
            phase_len   = $urandom_range(30, 90);
            r           = $urandom_range(2);
            ins_pct     = (r == 0) ? 85 : (r == 1) ? 55 : 25;
            narrow      = $urandom_range(1);
            tx_calm     = ($urandom_range(3) == 0);
            drain_first = (n_random == 0) || ($urandom_range(4) == 0);
            for (int k = 0; k < phase_len && n_random < RANDOM_REQS; k++) begin
                r = $urandom_range(99);
                if (r < ins_pct)
                    op = OP_INSERT;
                else if (r < 97)
                    op = OP_REMOVE;
                else if (r < 99)
                    op = OP_CLEAR;
                else
                    op = OP_SPARE;
                if (!narrow)
                    prio = 8'($urandom_range(255));
                else if ($urandom_range(1))
                    prio = 8'($urandom_range(3));
                else
                    prio = 8'(252 + $urandom_range(3));
                push_req(op, 8'($urandom_range(255)), prio, drain_first && k == 0);
                n_random++;
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid || predicted_status.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (predicted_status.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", predicted_status.size()));

        $display("Ran %0d requests: %0d inserts (%0d refused when full), %0d pops,",
                 n_results, n_inserts, n_dropped, n_pops);
        $display("%0d pops on empty, %0d clears, %0d spare-code requests; deepest fill %0d of %0d",
                 n_empty, n_clears, n_spare, max_fill, DEPTH);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/prq_pkg.sv
rtl/core/prq_cell.sv
rtl/core/priority_ready_queue.sv
bench/priority_ready_queue_test.sv
